[sv/twgmc_pkg.sv]
package twgmc_pkg;
	localparam int TOTAL_W = 33;
	localparam logic [TOTAL_W-1:0] TOTAL_CAP = {1'b1, 32'd0};
	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] COLS_RESET = 5'd4;

	typedef logic [TOTAL_W-1:0] total_t;

	function automatic total_t sat_add(input total_t a, input total_t b);
		logic [TOTAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > {1'b0, TOTAL_CAP}) return TOTAL_CAP;
		return s[TOTAL_W-1:0];
	endfunction
endpackage

[sv/twgmc_ram.sv]
module twgmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[sv/two_walker_grid_max_collect.sv]
// Two-walker grid collector.
// Input words on s_axis carry one grid cell each in row-major order: tdata holds
// cell_value, tlast marks the final cell of the grid. column_count (cfg_we/cfg_data)
// sets the row length; a write also restarts the grid.
// Cells that do not end a row are only stored in the row buffer. A row end runs a sweep over
// all column pairs of the pair table, which lives in two ping-pong RAMs with one
// read port each; every pair takes 9 predecessor reads plus a write slot, and no
// new word is taken until the sweep is done.
// On the final cell a further scan over the C*C new entries finds the maximum,
// and the result goes to m_axis: tdata holds best_total, tuser
// holds saturated. The result register holds while m_axis_tready is low and no
// new word is taken until the result has left.
// Reset sets column_count to 4 and starts an empty grid; the pair RAMs need no
// clearing because every sweep rewrites each entry that is read later, with a
// valid bit stored beside its total.
module two_walker_grid_max_collect #(
	parameter int MAX_COLUMNS = 16,
	parameter int VALUE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,      // column_count [4:0]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // cell_value [15:0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // best_total [31:0]
	output logic        m_axis_tuser   // saturated
);
	import twgmc_pkg::*;

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int PW = 2 * CW;
	localparam int PAIRS = 1 << PW;
	localparam int NW = $clog2(MAX_COLUMNS + 1);

	localparam logic [2:0] ST_IN = 3'd0, ST_RD = 3'd1, ST_WR = 3'd2, ST_SCAN = 3'd3,
		ST_OUT = 3'd4;

	logic [2:0] state_q;
	logic [CFG_W-1:0] cols_q;
	logic [CW-1:0] col_q;
	logic first_q, last_q, bank_q;
	logic [VALUE_WIDTH-1:0] row_q [MAX_COLUMNS];
	logic [CW-1:0] a_q, b_q;
	logic [3:0] k_q;
	logic pend_q;
	total_t best_q;
	logic ok_q;
	logic [31:0] out_q;
	logic sat_q, ovalid_q;

	// active column count
	logic [NW-1:0] ncol;
	always_comb begin
		if (cols_q == '0) ncol = NW'(1);
		else if ({27'd0, cols_q} > 32'(MAX_COLUMNS)) ncol = NW'(MAX_COLUMNS);
		else ncol = NW'(cols_q);
	end
	logic [CW-1:0] clast;
	assign clast = CW'(ncol - NW'(1));

	// predecessor of (a,b) for read step k; offsets are stored biased by one
	logic [1:0] oa, ob;
	logic signed [CW+1:0] pa, pb;
	logic in_range;
	always_comb begin
		case (k_q)
			4'd0: begin oa = 2'd0; ob = 2'd0; end
			4'd1: begin oa = 2'd0; ob = 2'd1; end
			4'd2: begin oa = 2'd0; ob = 2'd2; end
			4'd3: begin oa = 2'd1; ob = 2'd0; end
			4'd4: begin oa = 2'd1; ob = 2'd1; end
			4'd5: begin oa = 2'd1; ob = 2'd2; end
			4'd6: begin oa = 2'd2; ob = 2'd0; end
			4'd7: begin oa = 2'd2; ob = 2'd1; end
			4'd8: begin oa = 2'd2; ob = 2'd2; end
			default: begin oa = 2'd0; ob = 2'd0; end
		endcase
		pa = $signed({2'b0, a_q} + {{CW{1'b0}}, oa} - (CW+2)'(1));
		pb = $signed({2'b0, b_q} + {{CW{1'b0}}, ob} - (CW+2)'(1));
		in_range = (pa >= 0) && (pb >= 0) && (pa <= $signed({2'b0, clast}))
			&& (pb <= $signed({2'b0, clast}));
	end
	logic [PW-1:0] rd_addr, cur_addr;
	assign rd_addr = {pa[CW-1:0], pb[CW-1:0]};
	assign cur_addr = {a_q, b_q};

	// RAM ports: bank_q names the bank holding the previous row.
	// Each RAM word holds a valid bit above the total.
	logic we0, we1;
	logic [PW-1:0] raddr;
	logic [TOTAL_W:0] rdata0, rdata1, wword, prev_word;
	total_t wdata, prev_rd;
	logic prev_ok;
	assign prev_word = bank_q ? rdata1 : rdata0;
	assign prev_rd = prev_word[TOTAL_W-1:0];
	assign prev_ok = prev_word[TOTAL_W];

	total_t gain, nbest, fin;
	logic nok, pair_ok;
	always_comb begin
		gain = total_t'(row_q[a_q]);
		if (a_q != b_q) gain = sat_add(gain, total_t'(row_q[b_q]));
		nbest = best_q;
		nok = ok_q;
		if (pend_q && !first_q && prev_ok) begin
			if (!ok_q || prev_rd > best_q) nbest = prev_rd;
			nok = 1'b1;
		end
		pair_ok = first_q ? (a_q == '0 && b_q == clast) : nok;
		wdata = sat_add(first_q ? '0 : nbest, gain);
	end
	assign wword = {pair_ok, wdata};
	assign fin = (pend_q && prev_ok && prev_rd > best_q) ? prev_rd : best_q;

	assign raddr = (state_q == ST_SCAN) ? cur_addr : rd_addr;
	assign we0 = (state_q == ST_WR) && bank_q;
	assign we1 = (state_q == ST_WR) && !bank_q;

	twgmc_ram #(.WIDTH(TOTAL_W + 1), .DEPTH(PAIRS)) u_bank0 (
		.clk(clk), .we(we0), .waddr(cur_addr), .wdata(wword), .raddr(raddr),
		.rdata(rdata0));
	twgmc_ram #(.WIDTH(TOTAL_W + 1), .DEPTH(PAIRS)) u_bank1 (
		.clk(clk), .we(we1), .waddr(cur_addr), .wdata(wword), .raddr(raddr),
		.rdata(rdata1));

	logic in_acc, out_acc;
	assign s_axis_tready = (state_q == ST_IN) && !ovalid_q;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	logic [CW-1:0] wcol;
	assign wcol = (col_q > clast) ? '0 : col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_COLUMNS; i++) row_q[i] <= '0;
		end else begin
			if (in_acc) row_q[wcol] <= VALUE_WIDTH'(s_axis_tdata);
			if ((state_q == ST_WR && a_q == clast && b_q == clast) || cfg_we)
				for (int i = 0; i < MAX_COLUMNS; i++) row_q[i] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IN;
			cols_q <= COLS_RESET;
			col_q <= '0;
			first_q <= 1'b1;
			last_q <= 1'b0;
			bank_q <= 1'b0;
			a_q <= '0;
			b_q <= '0;
			k_q <= '0;
			pend_q <= 1'b0;
			best_q <= '0;
			ok_q <= 1'b0;
			out_q <= '0;
			sat_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_acc) ovalid_q <= 1'b0;
			case (state_q)
				ST_IN: begin
					if (in_acc) begin
						last_q <= s_axis_tlast;
						if (s_axis_tlast || wcol == clast) begin
							state_q <= ST_RD;
							a_q <= '0;
							b_q <= '0;
							k_q <= '0;
							pend_q <= 1'b0;
							ok_q <= 1'b0;
							best_q <= '0;
						end else begin
							col_q <= wcol + CW'(1);
						end
					end
				end
				ST_RD: begin
					best_q <= nbest;
					ok_q <= nok;
					pend_q <= in_range;
					if (k_q == 4'd8) state_q <= ST_WR;
					else k_q <= k_q + 4'd1;
				end
				ST_WR: begin
					pend_q <= 1'b0;
					ok_q <= 1'b0;
					best_q <= '0;
					k_q <= '0;
					if (b_q != clast) begin
						b_q <= b_q + CW'(1);
						state_q <= ST_RD;
					end else if (a_q != clast) begin
						b_q <= '0;
						a_q <= a_q + CW'(1);
						state_q <= ST_RD;
					end else begin
						bank_q <= !bank_q;
						first_q <= 1'b0;
						col_q <= '0;
						a_q <= '0;
						b_q <= '0;
						state_q <= last_q ? ST_SCAN : ST_IN;
					end
				end
				ST_SCAN: begin
					// cur_addr is read this cycle, the previous entry is folded in
					pend_q <= 1'b1;
					best_q <= fin;
					if (b_q != clast) b_q <= b_q + CW'(1);
					else if (a_q != clast) begin
						b_q <= '0;
						a_q <= a_q + CW'(1);
					end else state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (fin >= TOTAL_CAP) begin
						out_q <= 32'hFFFF_FFFF;
						sat_q <= 1'b1;
					end else begin
						out_q <= fin[31:0];
						sat_q <= 1'b0;
					end
					ovalid_q <= 1'b1;
					first_q <= 1'b1;
					col_q <= '0;
					pend_q <= 1'b0;
					best_q <= '0;
					state_q <= ST_IN;
				end
				default: state_q <= ST_IN;
			endcase
			if (cfg_we) begin
				cols_q <= cfg_data[CFG_W-1:0];
				col_q <= '0;
				first_q <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = out_q;
	assign m_axis_tuser = sat_q;
endmodule

[sv/two_walker_grid_max_collect_checker.sv]
module two_walker_grid_max_collect_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);
	// A stalled result must hold.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// Saturation always reports the all-ones total.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'hFFFF_FFFF)
		else $error("saturated flag with unclipped total");
	// No input is taken while a result waits.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input accepted while result pending");
	// The final word always starts a row sweep, so the next cycle takes no word.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input accepted right after final word");
endmodule

bind two_walker_grid_max_collect two_walker_grid_max_collect_checker u_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .s_axis_tlast(s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser));
